// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ADDR_W = $clog2(CELL_COUNT);

   // Channel field widths.
   localparam int KIND_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int INDEX_W   = 11;
   localparam int OUT_ROW_W = 5;
   localparam int OUT_COL_W = 7;
   localparam int CELL_W    = ATTR_W + CHAR_W;

   localparam logic [ROW_W:0]       ROW_LIMIT    = ROWS[ROW_W:0];
   localparam logic [COL_W:0]       COL_LIMIT    = COLUMNS[COL_W:0];
   localparam logic [ROW_W-1:0]     LAST_ROW     = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]     LAST_COL     = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0]    COLUMNS_ADDR = ADDR_W'(COLUMNS);
   localparam logic [INDEX_W-1:0]   COLUMNS_IDX  = INDEX_W'(COLUMNS);

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

   typedef struct packed {
      logic load_req;
      logic fill_step;
      logic write_char;
      logic advance;
      logic do_clear;
      logic div_step;
      logic rd_issue;
      logic rsp_load;
   } tcw_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              is_newline;
      logic              row_blank;
      logic              fill_last;
      logic              div_done;
      logic              in_range;
      logic              rsp_free;
   } tcw_status_type;

endpackage

// ===== rtl/core/tcw_channels.sv =====
interface tcw_req_if import tcw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [CHAR_W-1:0]  char_code;
   logic [INDEX_W-1:0] cell_index;

   modport source (output valid, kind, char_code, cell_index, input ready);
   modport sink   (input valid, kind, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUT_ROW_W-1:0] cursor_row;
   logic [OUT_COL_W-1:0] cursor_col;
   logic                 scrolled;
   logic [CHAR_W-1:0]    cell_char;
   logic [ATTR_W-1:0]    cell_attr;

   modport source (output valid, cursor_row, cursor_col, scrolled, cell_char, cell_attr,
                   input ready);
   modport sink   (input valid, cursor_row, cursor_col, scrolled, cell_char, cell_attr,
                   output ready);
endinterface

interface tcw_csr_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/tcw_ram.sv =====
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tcw_datapath.sv =====
module tcw_datapath import tcw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  tcw_cmd_type          cmd,
   output tcw_status_type       status,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [INDEX_W-1:0]   req_cell_index,
   input  logic                 csr_valid,
   input  logic [ATTR_W-1:0]    csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_ROW_W-1:0] rsp_cursor_row,
   output logic [OUT_COL_W-1:0] rsp_cursor_col,
   output logic                 rsp_scrolled,
   output logic [CHAR_W-1:0]    rsp_cell_char,
   output logic [ATTR_W-1:0]    rsp_cell_attr
);

   // Latched item.
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 in_range_ff, in_range_in;
   logic [INDEX_W-1:0]   rem_ff, rem_in;
   logic [ROW_W-1:0]     quo_ff, quo_in;
   logic [COL_W-1:0]     fill_col_ff, fill_col_in;

   // Console state. A blank row reads as spaces in its own fill attribute,
   // so clear and scroll only touch these flags; the row is written out
   // to the cell store the first time a character lands in it.
   logic [ATTR_W-1:0]    attr_ff, attr_in;
   logic [ROW_W-1:0]     cur_row_ff, cur_row_in;
   logic [COL_W-1:0]     cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]     base_ff, base_in;
   logic [ROWS-1:0]      blank_ff, blank_in;
   logic [ATTR_W-1:0]    battr_ff [ROWS];
   logic [ATTR_W-1:0]    battr_in [ROWS];
   logic                 scrolled_ff, scrolled_in;
   logic                 rd_blank_ff, rd_blank_in;
   logic [ATTR_W-1:0]    rd_battr_ff, rd_battr_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [OUT_COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic                 rsp_scrolled_ff, rsp_scrolled_in;
   logic [CELL_W-1:0]    rsp_cell_ff, rsp_cell_in;

   logic [ROW_W-1:0]     op_row;
   logic [ROW_W:0]       row_sum;
   logic [ROW_W-1:0]     prow;
   logic [COL_W-1:0]     col_sel;
   logic [ADDR_W-1:0]    cell_addr;
   logic                 ram_wr_en;
   logic [CELL_W-1:0]    ram_wr_data;
   logic [CELL_W-1:0]    ram_rd_data;
   logic [COL_W:0]       col_inc;
   logic                 wrap;
   logic [ROW_W:0]       row_inc;
   logic [ROW_W-1:0]     base_inc;
   logic                 read_hit;

   // Logical row to physical row through the rotating row base.
   always_comb begin
      op_row  = (kind_ff == KIND_READ) ? quo_ff : cur_row_ff;
      row_sum = {1'b0, op_row} + {1'b0, base_ff};
      if (row_sum >= ROW_LIMIT) begin
         prow = ROW_W'(row_sum - ROW_LIMIT);
      end else begin
         prow = ROW_W'(row_sum);
      end
      if (cmd.fill_step) begin
         col_sel = fill_col_ff;
      end else if (kind_ff == KIND_READ) begin
         col_sel = COL_W'(rem_ff);
      end else begin
         col_sel = cur_col_ff;
      end
      cell_addr   = ADDR_W'(prow) * COLUMNS_ADDR + ADDR_W'(col_sel);
      ram_wr_en   = cmd.fill_step | cmd.write_char;
      ram_wr_data = cmd.fill_step ? {battr_ff[prow], SPACE_CODE} : {attr_ff, char_ff};
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cell_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (cell_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      col_inc  = {1'b0, cur_col_ff} + {{COL_W{1'b0}}, 1'b1};
      wrap     = (char_ff == NEWLINE_CODE) || (col_inc == COL_LIMIT);
      row_inc  = {1'b0, cur_row_ff} + {{ROW_W{1'b0}}, wrap};
      base_inc = (base_ff == LAST_ROW) ? '0 : base_ff + {{(ROW_W-1){1'b0}}, 1'b1};
      read_hit = (kind_ff == KIND_READ) && in_range_ff;
   end

   always_comb begin
      kind_in         = kind_ff;
      char_in         = char_ff;
      in_range_in     = in_range_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      fill_col_in     = fill_col_ff;
      attr_in         = attr_ff;
      cur_row_in      = cur_row_ff;
      cur_col_in      = cur_col_ff;
      base_in         = base_ff;
      blank_in        = blank_ff;
      battr_in        = battr_ff;
      scrolled_in     = scrolled_ff;
      rd_blank_in     = rd_blank_ff;
      rd_battr_in     = rd_battr_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_row_in      = rsp_row_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_cell_in     = rsp_cell_ff;

      if (csr_valid) begin
         attr_in = csr_data;
      end

      if (cmd.load_req) begin
         kind_in     = req_kind;
         char_in     = req_char_code;
         in_range_in = 32'(req_cell_index) < CELL_COUNT;
         rem_in      = req_cell_index;
         quo_in      = '0;
         fill_col_in = '0;
         scrolled_in = 1'b0;
      end

      if (cmd.fill_step) begin
         fill_col_in = fill_col_ff + {{(COL_W-1){1'b0}}, 1'b1};
         if (fill_col_ff == LAST_COL) begin
            blank_in[prow] = 1'b0;
         end
      end

      if (cmd.advance) begin
         if (row_inc == ROW_LIMIT) begin
            // The top row rotates round to become the new, blank bottom row.
            blank_in[base_ff] = 1'b1;
            battr_in[base_ff] = attr_ff;
            base_in           = base_inc;
            cur_row_in        = LAST_ROW;
            cur_col_in        = '0;
            scrolled_in       = 1'b1;
         end else begin
            cur_row_in = ROW_W'(row_inc);
            cur_col_in = wrap ? '0 : COL_W'(col_inc);
         end
      end

      if (cmd.do_clear) begin
         blank_in = '1;
         for (int i = 0; i < ROWS; i++) begin
            battr_in[i] = attr_ff;
         end
         cur_row_in = '0;
         cur_col_in = '0;
      end

      if (cmd.div_step) begin
         rem_in = rem_ff - COLUMNS_IDX;
         quo_in = quo_ff + {{(ROW_W-1){1'b0}}, 1'b1};
      end

      if (cmd.rd_issue) begin
         rd_blank_in = blank_ff[prow];
         rd_battr_in = battr_ff[prow];
      end

      if (cmd.rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_row_in      = OUT_ROW_W'(cur_row_ff);
         rsp_col_in      = OUT_COL_W'(cur_col_ff);
         rsp_scrolled_in = scrolled_ff;
         if (!read_hit) begin
            rsp_cell_in = '0;
         end else if (rd_blank_ff) begin
            rsp_cell_in = {rd_battr_ff, SPACE_CODE};
         end else begin
            rsp_cell_in = ram_rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      char_ff         <= char_in;
      in_range_ff     <= in_range_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      fill_col_ff     <= fill_col_in;
      scrolled_ff     <= scrolled_in;
      rd_blank_ff     <= rd_blank_in;
      rd_battr_ff     <= rd_battr_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_cell_ff     <= rsp_cell_in;
      if (reset) begin
         attr_ff      <= RESET_ATTR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         base_ff      <= '0;
         blank_ff     <= '1;
         for (int i = 0; i < ROWS; i++) begin
            battr_ff[i] <= RESET_ATTR;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         base_ff      <= base_in;
         blank_ff     <= blank_in;
         battr_ff     <= battr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      status.kind       = kind_ff;
      status.is_newline = char_ff == NEWLINE_CODE;
      status.row_blank  = blank_ff[prow];
      status.fill_last  = fill_col_ff == LAST_COL;
      status.div_done   = 32'(rem_ff) < COLUMNS;
      status.in_range   = in_range_ff;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_cell_char  = rsp_cell_ff[CHAR_W-1:0];
   assign rsp_cell_attr  = rsp_cell_ff[CELL_W-1:CHAR_W];

`ifndef ASSERT_OFF
   // A character is only ever written into a row that holds real cells.
   a_write_row_filled: assert property (@(posedge clock) disable iff (reset)
      cmd.write_char |-> !blank_ff[prow])
      else $error("character written into a blank row");

   // The last fill beat of a row hands that row over to the cell store.
   a_fill_unblanks: assert property (@(posedge clock) disable iff (reset)
      (cmd.fill_step && status.fill_last) |=> !blank_ff[$past(prow)])
      else $error("row still blank after its fill");

   // A scroll always leaves the cursor at the start of the bottom row.
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_scrolled_ff) |->
         (rsp_row_ff == OUT_ROW_W'(LAST_ROW)) && (rsp_col_ff == '0))
      else $error("scrolled result with cursor off the bottom row start");
`endif

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
module tcw_ctrl import tcw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  tcw_status_type status,
   output tcw_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_FILL     = 3'd2;
   localparam logic [2:0] S_WRITE    = 3'd3;
   localparam logic [2:0] S_ADVANCE  = 3'd4;
   localparam logic [2:0] S_DIV      = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;
   localparam logic [2:0] S_SPARE    = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == S_IDLE) && !reset;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.kind)
               KIND_PUT: begin
                  if (status.is_newline) begin
                     state_in = S_ADVANCE;
                  end else if (status.row_blank) begin
                     state_in = S_FILL;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
               KIND_CLEAR: begin
                  cmd.do_clear = 1'b1;
                  state_in     = S_FINISH;
               end
               KIND_READ: begin
                  state_in = status.in_range ? S_DIV : S_FINISH;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write_char = 1'b1;
            state_in       = S_ADVANCE;
         end
         S_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = S_FINISH;
         end
         S_DIV: begin
            // Split the cell number into row and column one row per beat.
            if (status.div_done) begin
               cmd.rd_issue = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SPARE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted beat not dispatched");

   a_fill_only_put: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (status.kind == KIND_PUT) && !status.is_newline)
      else $error("row fill outside a character put");

   a_no_spare_state: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_SPARE)
      else $error("controller in unused state");
`endif

endmodule

// ===== rtl/core/text_console_writer.sv =====
// Channel   Modport  Beat contents
// req_bus   sink     kind, char_code, cell_index
// rsp_bus   source   cursor_row, cursor_col, scrolled, cell_char, cell_attr
// csr_bus   sink     data: text attribute, ready whenever reset is low
//
// One item at a time. Clear, unused kinds and out-of-range reads pass through dispatch
// and finish; a put passes through dispatch, write, advance and finish (a newline skips
// write), and the fill sequencer first writes a blank row out to the cell store when
// the character lands in it. A read in range runs the one-row-per-cycle subtract loop
// between dispatch and finish. Scrolls rotate the row base and need no copy. Reset is
// synchronous and marks every row blank at once. A held result stalls the next one only.
module text_console_writer import tcw_pkg::*; (
   input logic        clock,
   input logic        reset,
   tcw_req_if.sink    req_bus,
   tcw_rsp_if.source  rsp_bus,
   tcw_csr_if.sink    csr_bus
);

   tcw_cmd_type    cmd;
   tcw_status_type status;
   logic           req_ready;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_bus.kind),
      .req_char_code  (req_bus.char_code),
      .req_cell_index (req_bus.cell_index),
      .csr_valid      (csr_bus.valid),
      .csr_data       (csr_bus.data),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_cursor_row (rsp_bus.cursor_row),
      .rsp_cursor_col (rsp_bus.cursor_col),
      .rsp_scrolled   (rsp_bus.scrolled),
      .rsp_cell_char  (rsp_bus.cell_char),
      .rsp_cell_attr  (rsp_bus.cell_attr)
   );

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = ~reset;

endmodule

// ===== bench/text_console_writer_test.sv =====
`timescale 1ns / 100ps

module text_console_writer_test;
   import tcw_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 200;
   localparam int STALL_LIMIT  = 5000;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic                 scrolled;
      logic [CHAR_W-1:0]    ch;
      logic [ATTR_W-1:0]    attr;
   } console_view_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [CHAR_W-1:0]  ch;
      logic [INDEX_W-1:0] idx;
      bit                 typed;
      console_view_type   view;
   } console_cmd_type;

   logic clock;
   logic reset;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();
   tcw_csr_if csr_bus ();

   text_console_writer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the screen, cursor and attribute register.
   logic [CELL_W-1:0] screen_shadow [CELL_COUNT];
   int unsigned       cursor_shadow;
   logic [ATTR_W-1:0] attr_shadow;

   console_view_type expected_views [$];
   console_cmd_type  directed_rows [$];

   int mismatch_count;
   int sender_idle_pct;
   int rsp_stall_pct;
   int newline_pct;
   int hold_orders;
   int holds_taken;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   function automatic console_view_type console_apply(input console_cmd_type c);
      console_view_type view;
      int unsigned      pos;
      view = '0;
      case (c.kind)
         KIND_PUT: begin
            pos = cursor_shadow;
            if (pos >= CELL_COUNT) pos = 0;
            if (c.ch == NEWLINE_CODE) begin
               pos = (pos / COLUMNS + 1) * COLUMNS;
            end else begin
               screen_shadow[pos] = {attr_shadow, c.ch};
               pos++;
            end
            if (pos >= CELL_COUNT) begin
               for (int i = 0; i + COLUMNS < CELL_COUNT; i++)
                  screen_shadow[i] = screen_shadow[i + COLUMNS];
               for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                  screen_shadow[i] = {attr_shadow, SPACE_CODE};
               pos = CELL_COUNT - COLUMNS;
               view.scrolled = 1'b1;
            end
            cursor_shadow = pos;
         end
         KIND_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++)
               screen_shadow[i] = {attr_shadow, SPACE_CODE};
            cursor_shadow = 0;
         end
         KIND_READ: begin
            if (c.idx < CELL_COUNT) {view.attr, view.ch} = screen_shadow[c.idx];
         end
         default: ;
      endcase
      view.row = OUT_ROW_W'(cursor_shadow / COLUMNS);
      view.col = OUT_COL_W'(cursor_shadow % COLUMNS);
      return view;
   endfunction

   // Leaves valid high after the beat so back-to-back items need no toggle.
   task automatic send_command(input console_cmd_type c);
      console_view_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= c.kind;
      req_bus.char_code  <= c.ch;
      req_bus.cell_index <= c.idx;
      do @(posedge clock); while (!req_bus.ready);
      predicted = console_apply(c);
      expected_views.push_back(c.typed ? c.view : predicted);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
   endtask

   task automatic write_attr(input logic [ATTR_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      attr_shadow = value;
      csr_bus.valid <= 1'b0;
   endtask

   // Result sink: random stalls, plus a long hold whenever one is ordered.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_orders != holds_taken) begin
            holds_taken++;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      console_view_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_views.size() == 0) begin
            report_mismatch($sformatf("unexpected beat: row %0d col %0d char %0d",
                                      rsp_bus.cursor_row, rsp_bus.cursor_col,
                                      rsp_bus.cell_char));
         end else begin
            want = expected_views.pop_front();
            check_field("cursor_row", 8'(rsp_bus.cursor_row), 8'(want.row));
            check_field("cursor_col", 8'(rsp_bus.cursor_col), 8'(want.col));
            check_field("scrolled", 8'(rsp_bus.scrolled), 8'(want.scrolled));
            check_field("cell_char", rsp_bus.cell_char, want.ch);
            check_field("cell_attr", rsp_bus.cell_attr, want.attr);
         end
      end
   end

   // Watchdog on cycles without any beat on any channel.
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      console_cmd_type c;
      int              pick;
      int unsigned     back;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_PUT;
      req_bus.char_code  = '0;
      req_bus.cell_index = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.data       = '0;
      mismatch_count     = 0;
      sender_idle_pct    = 0;
      rsp_stall_pct      = 0;
      newline_pct        = 15;
      hold_orders        = 0;
      holds_taken        = 0;
      attr_shadow        = RESET_ATTR;
      cursor_shadow      = 0;
      for (int i = 0; i < CELL_COUNT; i++) screen_shadow[i] = {RESET_ATTR, SPACE_CODE};

      directed_rows = '{
         '{KIND_READ,  8'h00,        11'd0,    1'b1, '{5'd0, 7'd0, 1'b0, SPACE_CODE, RESET_ATTR}},
         '{KIND_READ,  8'hFF,        11'd1999, 1'b1, '{5'd0, 7'd0, 1'b0, SPACE_CODE, RESET_ATTR}},
         '{KIND_READ,  8'h00,        11'd2000, 1'b1, '0},
         '{KIND_READ,  8'h00,        11'h7FF,  1'b1, '0},
         '{KIND_SPARE, 8'hFF,        11'h7FF,  1'b1, '0},
         '{KIND_PUT,   8'h41,        11'h7FF,  1'b1, '{5'd0, 7'd1, 1'b0, 8'd0, 8'd0}},
         '{KIND_PUT,   8'hFF,        11'd0,    1'b0, '0},
         '{KIND_PUT,   8'h00,        11'd0,    1'b0, '0},
         '{KIND_READ,  8'h00,        11'd0,    1'b0, '0},
         '{KIND_READ,  8'h00,        11'd2,    1'b0, '0},
         '{KIND_PUT,   NEWLINE_CODE, 11'd0,    1'b0, '0},
         '{KIND_PUT,   NEWLINE_CODE, 11'd0,    1'b0, '0},
         '{KIND_PUT,   SPACE_CODE,   11'd0,    1'b0, '0},
         '{KIND_READ,  8'h00,        11'd160,  1'b0, '0},
         '{KIND_SPARE, NEWLINE_CODE, 11'd0,    1'b0, '0},
         '{KIND_CLEAR, 8'hFF,        11'h7FF,  1'b1, '0},
         '{KIND_READ,  8'h00,        11'd0,    1'b1, '{5'd0, 7'd0, 1'b0, SPACE_CODE, RESET_ATTR}},
         '{KIND_PUT,   8'h7E,        11'd0,    1'b0, '0},
         '{KIND_READ,  8'h00,        11'd1,    1'b0, '0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_command(directed_rows[i]);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 88; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 88; end
            default: begin sender_idle_pct = 29; rsp_stall_pct = 29; end
         endcase
         // Odd phases send long lines so that the cursor wraps past the last column.
         newline_pct = (p % 2 == 1) ? 1 : 15;
         if (p == 1)
            write_attr(8'hFF);
         else if (p == 2)
            write_attr(8'h00);
         else if (p > 2)
            write_attr(ATTR_W'($urandom_range(255)));

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == 100) hold_orders++;
            if (p == 5 && n == 100) wait_drained();
            c.typed = 1'b0;
            c.view  = '0;
            c.ch    = CHAR_W'($urandom_range(255));
            c.idx   = INDEX_W'($urandom_range(2047));
            pick    = $urandom_range(999);
            if (pick < 3) begin
               c.kind = KIND_CLEAR;
            end else if (pick < 20) begin
               c.kind = KIND_SPARE;
            end else if (pick < 220) begin
               c.kind = KIND_READ;
               back   = $urandom_range(160, 1);
               case ($urandom_range(2))
                  0: ;
                  1: c.idx = INDEX_W'($urandom_range(CELL_COUNT - 1));
                  default: if (cursor_shadow >= back) c.idx = INDEX_W'(cursor_shadow - back);
               endcase
            end else begin
               c.kind = KIND_PUT;
               if ($urandom_range(99) < newline_pct)
                  c.ch = NEWLINE_CODE;
               else if ($urandom_range(9) < 8)
                  c.ch = CHAR_W'($urandom_range(126, 32));
            end
            send_command(c);
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_views.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_views.size()));

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
